>>> rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
`default_nettype none

package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   // Fixed field widths
   localparam int CMD_W  = 2;
   localparam int CHAR_W = 8;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int CELL_W = 16;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // Special characters and the blank cell
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [CHAR_W-1:0] char_code;
      logic [CHAR_W-1:0] color;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_col;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
      logic [CELL_W-1:0] cell_word;
      logic              scrolled;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load_req;
      logic exec;
      logic write_char;
      logic col_zero;
      logic col_inc;
      logic line_inc;
      logic scroll_start;
      logic clear_start;
      logic sweep_write;
      logic read_capture;
      logic load_rsp;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_put;
      logic is_clear;
      logic is_read;
      logic is_cr;
      logic is_lf;
      logic last_col;
      logic last_row;
      logic sweep_last;
      logic rsp_free;
   } dp_status_type;

   typedef enum logic [2:0] {
      ST_BOOT,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCROLL,
      ST_CLEAR,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

>>> rtl/tcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/tcw_ctrl.sv
// Controller state machine for the text console writer.
`default_nettype none

module tcw_ctrl
   import tcw_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire dp_status_type status,
   output ctl_cmd_type        cmd
);

   state_type state_ff;
   state_type state_in;
   logic      new_line;

   // A line break is needed after a line feed or a character in the last column
   assign new_line = status.is_lf || (!status.is_cr && status.last_col);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BOOT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_BOOT: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESULT;
            if (status.is_put) begin
               if (new_line && status.last_row) state_in = ST_SCROLL;
            end else if (status.is_clear) begin
               state_in = ST_CLEAR;
            end else if (status.is_read) begin
               state_in = ST_READ;
            end
         end
         ST_READ:   state_in = ST_RESULT;
         ST_SCROLL: begin
            if (status.sweep_last) state_in = ST_RESULT;
         end
         ST_CLEAR: begin
            if (status.sweep_last) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_BOOT;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_BOOT: begin
            cmd.sweep_write = 1'b1;
         end
         ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.is_put) begin
               cmd.write_char = !status.is_cr && !status.is_lf;
               if (status.is_cr) begin
                  cmd.col_zero = 1'b1;
               end else if (new_line) begin
                  cmd.col_zero     = 1'b1;
                  cmd.line_inc     = !status.last_row;
                  cmd.scroll_start = status.last_row;
               end else begin
                  cmd.col_inc = 1'b1;
               end
            end else if (status.is_clear) begin
               cmd.clear_start = 1'b1;
            end
         end
         ST_READ: begin
            cmd.read_capture = 1'b1;
         end
         ST_SCROLL, ST_CLEAR: begin
            cmd.sweep_write = 1'b1;
         end
         ST_RESULT: begin
            cmd.load_rsp = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/tcw_datapath.sv
// Datapath: cursor, scroll offset, screen store and result register.
`default_nettype none

module tcw_datapath
   import tcw_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire req_type       req_data,
   output rsp_type            rsp_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  wire ctl_cmd_type   cmd,
   output dp_status_type      status
);

   req_type            req_ff;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   line_ff, line_in;
   logic [ROW_W-1:0]   top_ff, top_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic [ADDR_W-1:0]  sweep_end_ff, sweep_end_in;
   logic               scrolled_ff;
   logic [CELL_W-1:0]  cell_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic [ADDR_W-1:0]  cur_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  top_base;
   logic               read_in_range;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [CELL_W-1:0]  wr_data;
   logic [CELL_W-1:0]  rd_data;

   // The store is a ring of rows; top_ff holds the physical row shown at the top
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                 input logic [ROW_W-1:0] top);
      logic [ROW_W:0] sum;
      sum = {1'b0, row} + {1'b0, top};
      if (sum >= (ROW_W+1)'(ROWS)) sum = sum - (ROW_W+1)'(ROWS);
      return sum[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

   assign cur_addr = cell_addr(phys_row(line_ff, top_ff), col_ff);
   assign rd_addr  = cell_addr(phys_row(req_ff.read_row, top_ff), req_ff.read_col);
   assign top_base = cell_addr(top_ff, '0);

   assign read_in_range = ({1'b0, req_ff.read_row} < (ROW_W+1)'(ROWS))
                       && ({1'b0, req_ff.read_col} < (COL_W+1)'(COLUMNS));

   // Status decode
   always_comb begin
      status            = '0;
      status.is_put     = (req_ff.command == CMD_PUT);
      status.is_clear   = (req_ff.command == CMD_CLEAR);
      status.is_read    = (req_ff.command == CMD_READ);
      status.is_cr      = (req_ff.char_code == CHAR_CR);
      status.is_lf      = (req_ff.char_code == CHAR_LF);
      status.last_col   = (col_ff == COL_W'(COLUMNS - 1));
      status.last_row   = (line_ff == ROW_W'(ROWS - 1));
      status.sweep_last = (sweep_ff == sweep_end_ff);
      status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Cursor, ring offset and sweep counter
   always_comb begin
      col_in       = col_ff;
      line_in      = line_ff;
      top_in       = top_ff;
      sweep_in     = sweep_ff;
      sweep_end_in = sweep_end_ff;
      if (cmd.col_zero) col_in = '0;
      if (cmd.col_inc)  col_in = col_ff + 1'b1;
      if (cmd.line_inc) line_in = line_ff + 1'b1;
      if (cmd.scroll_start) begin
         // the old top row becomes the new bottom row and is blanked
         top_in       = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + 1'b1;
         sweep_in     = top_base;
         sweep_end_in = top_base + ADDR_W'(COLUMNS - 1);
      end
      if (cmd.clear_start) begin
         col_in       = '0;
         line_in      = '0;
         top_in       = '0;
         sweep_in     = '0;
         sweep_end_in = ADDR_W'(CELL_COUNT - 1);
      end
      if (cmd.sweep_write && !status.sweep_last) sweep_in = sweep_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         line_ff      <= '0;
         top_ff       <= '0;
         sweep_ff     <= '0;
         sweep_end_ff <= ADDR_W'(CELL_COUNT - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         line_ff      <= line_in;
         top_ff       <= top_in;
         sweep_ff     <= sweep_in;
         sweep_end_ff <= sweep_end_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request, per-request result fields and output register
   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_data;
      if (cmd.exec) begin
         scrolled_ff <= cmd.scroll_start;
         cell_ff     <= '0;
      end
      if (cmd.read_capture) cell_ff <= read_in_range ? rd_data : '0;
      if (cmd.load_rsp) begin
         rsp_ff.cursor_col <= col_ff;
         rsp_ff.cursor_row <= line_ff;
         rsp_ff.cell_word  <= cell_ff;
         rsp_ff.scrolled   <= scrolled_ff;
      end
   end

   // Store write: blanking sweep or character put
   assign wr_en   = cmd.sweep_write || cmd.write_char;
   assign wr_addr = cmd.sweep_write ? sweep_ff : cur_addr;
   assign wr_data = cmd.sweep_write ? BLANK_CELL : {req_ff.color, req_ff.char_code};

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/text_console_writer_core.sv
// Top level of the text console writer.
`default_nettype none

// Text-mode console engine over an 80 x 25 store of 16-bit cells (colour in the
// high byte, character in the low byte) kept in one RAM with one write port.
// The rows form a ring, so a scroll only moves the top-row pointer and blanks
// one row. After reset the block blanks the whole store, one cell a cycle, and
// takes no request until that sweep ends. One request is handled at a time: a
// put, carriage return or line feed runs the execute and result states, a read
// adds a read state, and a scroll or clear adds a blanking sweep of one row or
// of the whole store, paced by the single RAM write port. A finished result
// waits in an output register while the next request is accepted.
module text_console_writer_core
   import tcw_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire
